// ===== design/rkln_pkg.sv =====
// shared types and constants for the ring key lookup node
`default_nettype none

package rkln_pkg;

  localparam int ID_BITS       = 6;
  localparam int WORD_W        = 7;
  localparam int RANK_W        = 7;
  localparam int RAND_W        = 16;
  localparam int CMP_W         = (ID_BITS > WORD_W) ? ID_BITS : WORD_W;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = RAND_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);

  localparam logic [RANK_W-1:0] OWN_RANK_RST = RANK_W'(1);

  typedef enum logic [3:0] {
    ACT_LOOKUP       = 4'd0,
    ACT_LOOKUP_REPLY = 4'd1,
    ACT_LEAVE        = 4'd2,
    ACT_LEAVE_REPLY  = 4'd3,
    ACT_JOIN         = 4'd4,
    ACT_JOIN_REPLY   = 4'd5,
    ACT_IGNORE       = 4'd6,
    ACT_START_LOOKUP = 4'd7,
    ACT_START_LEAVE  = 4'd8,
    ACT_START_JOIN   = 4'd9,
    ACT_LOAD_STATE   = 4'd10
  } act_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOOKUP,
    OP_LOOKUP_REPLY,
    OP_LEAVE,
    OP_LEAVE_REPLY,
    OP_JOIN,
    OP_JOIN_REPLY,
    OP_IGNORE,
    OP_START_LOOKUP,
    OP_START_LEAVE,
    OP_START_JOIN,
    OP_LOAD_STATE
  } op_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP       = 3'd0,
    KIND_LOOKUP_REPLY = 3'd1,
    KIND_LEAVE        = 3'd2,
    KIND_LEAVE_REPLY  = 3'd3,
    KIND_JOIN         = 3'd4,
    KIND_JOIN_REPLY   = 3'd5,
    KIND_IGNORE       = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    REP_NONE        = 2'd0,
    REP_LOOKUP_DONE = 2'd1,
    REP_LEAVE_DONE  = 2'd2,
    REP_NOT_FOUND   = 2'd3
  } report_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [WORD_W-1:0] word_c;
    logic [WORD_W-1:0] word_d;
    logic [WORD_W-1:0] word_e;
    logic [RAND_W-1:0] random_word;
    logic [RANK_W-1:0] target_peer;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    kind_t             send_kind;
    logic [RANK_W-1:0] send_dest;
    logic [WORD_W-1:0] out_a;
    logic [WORD_W-1:0] out_b;
    logic [WORD_W-1:0] out_c;
    logic [WORD_W-1:0] out_d;
    logic [WORD_W-1:0] out_e;
    report_t           report;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== design/rkln_front.sv =====
// front stage: takes input transfers and classifies them into commands
`default_nettype none

module rkln_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_stall,
  input  rkln_pkg::in_item_t       in_data,
  input  rkln_pkg::q_stat_t        q_stat,
  output logic                     push,
  output rkln_pkg::cmd_t           push_data
);
  import rkln_pkg::*;

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;

  function automatic op_t classify(input logic [3:0] action);
    op_t op;
    case (action)
      ACT_LOOKUP:       op = OP_LOOKUP;
      ACT_LOOKUP_REPLY: op = OP_LOOKUP_REPLY;
      ACT_LEAVE:        op = OP_LEAVE;
      ACT_LEAVE_REPLY:  op = OP_LEAVE_REPLY;
      ACT_JOIN:         op = OP_JOIN;
      ACT_JOIN_REPLY:   op = OP_JOIN_REPLY;
      ACT_IGNORE:       op = OP_IGNORE;
      ACT_START_LOOKUP: op = OP_START_LOOKUP;
      ACT_START_LEAVE:  op = OP_START_LEAVE;
      ACT_START_JOIN:   op = OP_START_JOIN;
      ACT_LOAD_STATE:   op = OP_LOAD_STATE;
      default:          op = OP_NOP;
    endcase
    return op;
  endfunction

  assign push      = valid_r && !q_stat.full;
  assign in_stall  = valid_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push_data = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (accept) begin
      valid_nxt    = 1'b1;
      cmd_nxt.op   = classify(in_data.action);
      cmd_nxt.item = in_data;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ===== design/rkln_fifo.sv =====
// short command queue between front and back
`default_nettype none

module rkln_fifo (
  input  wire               logic clk,
  input  wire               logic rst_n,
  input  wire               logic push,
  input  rkln_pkg::cmd_t          push_data,
  input  wire               logic pop,
  output rkln_pkg::cmd_t          head,
  output rkln_pkg::q_stat_t       stat
);
  import rkln_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QDEPTH))
    else $error("queue count past depth");

endmodule

`default_nettype wire

// ===== design/rkln_back.sv =====
// back stage: node state, command execution, join remainder unit, output register
`default_nettype none

module rkln_back (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic cfg_we,
  input  wire                  logic [rkln_pkg::RANK_W-1:0] cfg_wdata,
  input  rkln_pkg::cmd_t             head,
  input  rkln_pkg::q_stat_t          q_stat,
  output logic                       pop,
  output logic                       out_valid,
  input  wire                  logic out_stall,
  output rkln_pkg::out_item_t        out_data
);
  import rkln_pkg::*;

  localparam int OWN_W = CMP_W + 1;
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  bk_state_t            state_r, state_nxt;
  logic [RANK_W-1:0]    own_rank_r, own_rank_nxt;
  logic [ID_BITS-1:0]   node_id_r, node_id_nxt;
  logic [ID_BITS-1:0]   fok_r, fok_nxt;
  logic [ID_BITS-1:0]   succ_id_r, succ_id_nxt;
  logic [RANK_W-1:0]    succ_rank_r, succ_rank_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_BITS-1:0]   rem_r, rem_nxt;
  logic [ID_BITS-1:0]   span_r, span_nxt;
  logic [RAND_W-1:0]    dvd_r, dvd_nxt;
  logic [WORD_W-1:0]    join_a_r, join_a_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 slot_free;
  logic                 produce;
  out_item_t            res;

  // combinational execution of the queue head
  logic                 ex_send;
  logic                 ex_div;
  kind_t                ex_kind;
  report_t              ex_rep;
  logic [RANK_W-1:0]    ex_dest;
  logic [WORD_W-1:0]    ex_a, ex_b, ex_c, ex_d, ex_e;
  logic [ID_BITS-1:0]   ex_node, ex_fok, ex_sid;
  logic [RANK_W-1:0]    ex_srank;
  out_item_t            ex_res;

  logic [ID_BITS-1:0]   div_rem;
  logic [RAND_W-1:0]    div_dvd;
  logic [ID_BITS-1:0]   join_id;

  function automatic logic [ID_BITS-1:0] to_id(input logic [WORD_W-1:0] word);
    logic [CMP_W-1:0] t;
    t = CMP_W'(word);
    return t[ID_BITS-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] to_word(input logic [ID_BITS-1:0] id);
    logic [CMP_W-1:0] t;
    t = CMP_W'(id);
    return t[WORD_W-1:0];
  endfunction

  function automatic logic id_eq(input logic [ID_BITS-1:0] id,
                                 input logic [WORD_W-1:0] word);
    return CMP_W'(id) == CMP_W'(word);
  endfunction

  // wrap-around ownership interval, full word width on the key
  function automatic logic owns(input logic [WORD_W-1:0]  key,
                                input logic [ID_BITS-1:0] fok,
                                input logic [ID_BITS-1:0] nid);
    logic [OWN_W-1:0] k, f, n, ring;
    k    = OWN_W'(key);
    f    = OWN_W'(fok);
    n    = OWN_W'(nid);
    ring = OWN_W'(1) << ID_BITS;
    if (f <= n) begin
      return (f <= k) && (k <= n);
    end
    return ((f <= k) && (k < ring)) || (k <= n);
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign join_id   = fok_r + rem_r;

  always_comb begin
    ex_send  = 1'b0;
    ex_div   = 1'b0;
    ex_kind  = KIND_LOOKUP;
    ex_rep   = REP_NONE;
    ex_dest  = succ_rank_r;
    ex_a     = head.item.word_a;
    ex_b     = head.item.word_b;
    ex_c     = head.item.word_c;
    ex_d     = head.item.word_d;
    ex_e     = head.item.word_e;
    ex_node  = node_id_r;
    ex_fok   = fok_r;
    ex_sid   = succ_id_r;
    ex_srank = succ_rank_r;
    case (head.op)
      OP_LOOKUP: begin
        ex_send = 1'b1;
        if (owns(head.item.word_b, fok_r, node_id_r)) begin
          ex_kind = KIND_LOOKUP_REPLY;
          ex_c    = to_word(node_id_r);
          ex_d    = own_rank_r;
        end
      end
      OP_LOOKUP_REPLY: begin
        if (id_eq(node_id_r, head.item.word_a)) begin
          ex_rep = REP_LOOKUP_DONE;
        end else begin
          ex_send = 1'b1;
          ex_kind = KIND_LOOKUP_REPLY;
        end
      end
      OP_LEAVE: begin
        ex_fok  = to_id(head.item.word_a);
        ex_c    = to_word(node_id_r);
        ex_d    = own_rank_r;
        ex_send = 1'b1;
        ex_kind = KIND_LEAVE_REPLY;
      end
      OP_LEAVE_REPLY: begin
        if (id_eq(succ_id_r, head.item.word_b)) begin
          ex_send  = 1'b1;
          ex_kind  = KIND_LEAVE_REPLY;
          ex_sid   = to_id(head.item.word_c);
          ex_srank = head.item.word_d;
        end else if (id_eq(node_id_r, head.item.word_b)) begin
          ex_rep = REP_LEAVE_DONE;
        end else begin
          ex_send = 1'b1;
          ex_kind = KIND_LEAVE_REPLY;
        end
      end
      OP_JOIN: begin
        if (fok_r == node_id_r) begin
          ex_send = 1'b1;
          ex_kind = KIND_JOIN;
        end else begin
          ex_div = 1'b1;
        end
      end
      OP_JOIN_REPLY: begin
        if (own_rank_r == head.item.word_a) begin
          ex_node  = to_id(head.item.word_b);
          ex_sid   = to_id(head.item.word_c);
          ex_srank = head.item.word_d;
          ex_fok   = to_id(head.item.word_e);
        end else begin
          if (id_eq(succ_id_r, head.item.word_c)) begin
            ex_sid   = to_id(head.item.word_b);
            ex_srank = head.item.word_a;
            ex_dest  = head.item.word_a;
          end
          ex_send = 1'b1;
          ex_kind = KIND_JOIN_REPLY;
        end
      end
      OP_IGNORE: begin
        if (id_eq(node_id_r, head.item.word_a)) begin
          if (!owns(head.item.word_b, fok_r, node_id_r)) begin
            ex_rep = REP_NOT_FOUND;
          end
        end else begin
          ex_send = 1'b1;
          ex_kind = KIND_IGNORE;
        end
      end
      OP_START_LOOKUP: begin
        ex_a    = to_word(node_id_r);
        ex_c    = '0;
        ex_d    = '0;
        ex_e    = '0;
        ex_send = 1'b1;
        ex_kind = owns(head.item.word_b, fok_r, node_id_r) ? KIND_IGNORE : KIND_LOOKUP;
      end
      OP_START_LEAVE: begin
        ex_a    = to_word(fok_r);
        ex_b    = to_word(node_id_r);
        ex_c    = '0;
        ex_d    = '0;
        ex_e    = '0;
        ex_send = 1'b1;
        ex_kind = KIND_LEAVE;
      end
      OP_START_JOIN: begin
        ex_a    = own_rank_r;
        ex_b    = '0;
        ex_c    = '0;
        ex_d    = '0;
        ex_e    = '0;
        ex_send = 1'b1;
        ex_kind = KIND_JOIN;
        ex_dest = head.item.target_peer;
      end
      OP_LOAD_STATE: begin
        ex_node  = to_id(head.item.word_a);
        ex_fok   = to_id(head.item.word_b);
        ex_sid   = to_id(head.item.word_c);
        ex_srank = head.item.word_d;
      end
      default: begin
      end
    endcase
  end

  // words are cleared when nothing is sent and nothing is reported
  always_comb begin
    ex_res.send_valid = ex_send;
    ex_res.send_kind  = ex_send ? ex_kind : KIND_LOOKUP;
    ex_res.send_dest  = ex_send ? ex_dest : '0;
    ex_res.report     = ex_rep;
    if (ex_send || ex_rep != REP_NONE) begin
      ex_res.out_a = ex_a;
      ex_res.out_b = ex_b;
      ex_res.out_c = ex_c;
      ex_res.out_d = ex_d;
      ex_res.out_e = ex_e;
    end else begin
      ex_res.out_a = '0;
      ex_res.out_b = '0;
      ex_res.out_c = '0;
      ex_res.out_d = '0;
      ex_res.out_e = '0;
    end
  end

  // restoring remainder, a few dividend bits per cycle
  always_comb begin
    logic [ID_BITS:0]   trial;
    logic [ID_BITS-1:0] r;
    logic [RAND_W-1:0]  d;
    r = rem_r;
    d = dvd_r;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {r, d[RAND_W-1]};
      d     = d << 1;
      if (trial >= {1'b0, span_r}) begin
        r = ID_BITS'(trial - {1'b0, span_r});
      end else begin
        r = trial[ID_BITS-1:0];
      end
    end
    div_rem = r;
    div_dvd = d;
  end

  always_comb begin
    state_nxt     = state_r;
    own_rank_nxt  = cfg_we ? cfg_wdata : own_rank_r;
    node_id_nxt   = node_id_r;
    fok_nxt       = fok_r;
    succ_id_nxt   = succ_id_r;
    succ_rank_nxt = succ_rank_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    dvd_nxt       = dvd_r;
    join_a_nxt    = join_a_r;
    pop           = 1'b0;
    produce       = 1'b0;
    res           = ex_res;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && slot_free) begin
          pop = 1'b1;
          if (ex_div) begin
            dvd_nxt    = head.item.random_word;
            rem_nxt    = '0;
            span_nxt   = node_id_r - fok_r;
            cnt_nxt    = '0;
            join_a_nxt = head.item.word_a;
            state_nxt  = BK_DIV;
          end else begin
            produce       = 1'b1;
            node_id_nxt   = ex_node;
            fok_nxt       = ex_fok;
            succ_id_nxt   = ex_sid;
            succ_rank_nxt = ex_srank;
          end
        end
      end
      BK_DIV: begin
        rem_nxt = div_rem;
        dvd_nxt = div_dvd;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        res.send_valid = 1'b1;
        res.send_kind  = KIND_JOIN_REPLY;
        res.send_dest  = succ_rank_r;
        res.out_a      = join_a_r;
        res.out_b      = to_word(join_id);
        res.out_c      = to_word(node_id_r);
        res.out_d      = own_rank_r;
        res.out_e      = to_word(fok_r);
        res.report     = REP_NONE;
        if (slot_free) begin
          produce   = 1'b1;
          fok_nxt   = join_id + 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      own_rank_r  <= OWN_RANK_RST;
      node_id_r   <= '0;
      fok_r       <= '0;
      succ_id_r   <= '0;
      succ_rank_r <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_rank_r  <= own_rank_nxt;
      node_id_r   <= node_id_nxt;
      fok_r       <= fok_nxt;
      succ_id_r   <= succ_id_nxt;
      succ_rank_r <= succ_rank_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    span_r     <= span_nxt;
    dvd_r      <= dvd_nxt;
    join_a_r   <= join_a_nxt;
    out_data_r <= out_data_nxt;
  end

  a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !pop)
    else $error("queue popped during join remainder");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> (span_r != '0 && rem_r < span_r))
    else $error("join remainder out of range");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && cnt_r != CNT_LAST) |=> state_r == BK_DIV)
    else $error("join remainder left early");

  a_produce_lands: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("result lost at output register");

endmodule

`default_nettype wire

// ===== design/ring_key_lookup_node_top.sv =====
// top level of the ring key lookup node
`default_nettype none

// ring key lookup node: one node of a successor-only hash ring
// - in channel (in_valid / in_stall / in_data): one message or local command
//   per transfer; every transfer gives exactly one result transfer
// - out channel (out_valid / out_stall / out_data): optional outgoing message
//   (send_valid, kind, destination rank, five words) plus a report code
// - cfg port: cfg_we writes cfg_wdata into the node's own rank, no read-back
// - path: a result passes the front register, the command queue and the
//   output register; a join that picks a new id also runs the remainder unit
// - throughput: one command per cycle while out_stall is low, except a join
//   that picks an id, which holds the back end in the remainder unit
//   that takes 4 bits of the 16-bit random draw per cycle
// - a front register and a 2-entry command queue sit between the input and
//   the executing back end, so input keeps flowing while a result waits
// - reset (rst_n low, synchronous) empties front, queue and output register,
//   clears node id, first owned key and successor, and sets own rank to 1
// - out_stall holds the result register; the back end then stops, the queue
//   fills, and in_stall rises once front register and queue are both full
module ring_key_lookup_node_top (
  input  wire                  logic clk,
  input  wire                  logic rst_n,
  input  wire                  logic in_valid,
  output logic                       in_stall,
  input  rkln_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  wire                  logic out_stall,
  output rkln_pkg::out_item_t        out_data,
  input  wire                  logic cfg_we,
  input  wire                  logic [rkln_pkg::RANK_W-1:0] cfg_wdata
);
  import rkln_pkg::*;

  // front to queue
  logic    push;
  cmd_t    push_data;

  // queue to back
  cmd_t    head;
  q_stat_t q_stat;
  logic    pop;

  // classify and register each input transfer
  rkln_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples front from back
  rkln_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // node state, execution, join id draw and output register
  rkln_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/ring_key_lookup_node_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the ring key lookup node top level
module ring_key_lookup_node_top_tb;
  import rkln_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int PHASES        = 4;
  // settle time after the last result, long enough that the node is truly idle
  localparam int SETTLE_CYCLES = 12;
  // worst correct run: ~1930 transfers, each with the longest input gap, the
  // longest result stall and a join that picks an id, stays below this limit
  localparam int CYCLE_LIMIT   = 600000;

  // action codes the node does not decode
  localparam logic [3:0] ACT_FIRST_UNUSED = 4'd11;
  localparam logic [3:0] ACT_LAST_UNUSED  = 4'd15;

  localparam logic [WORD_W-1:0] ID_MASK  = WORD_W'((1 << ID_BITS) - 1);
  localparam logic [WORD_W-1:0] RING_TOP = WORD_W'(1 << ID_BITS);
  localparam out_item_t NO_REPLY = '0;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [RANK_W-1:0] cfg_wdata = '0;

  // mirror of the node state; ids kept at word width, always masked
  logic [WORD_W-1:0] mirror_node_id;
  logic [WORD_W-1:0] mirror_first_key;
  logic [WORD_W-1:0] mirror_succ_id;
  logic [RANK_W-1:0] mirror_succ_rank;
  logic [RANK_W-1:0] mirror_own_rank;

  // predicted results in transfer order
  out_item_t replies_due[$];

  // directed table
  in_item_t  dir_in[$];
  logic      dir_known[$];
  out_item_t dir_exp[$];

  int   mismatch_count  = 0;
  int   replies_seen    = 0;
  int   cycle_count     = 0;
  int   stall_left      = 0;
  logic sender_gaps     = 1'b0;
  logic receiver_stalls = 1'b0;

  ring_key_lookup_node_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ownership window runs from first owned key up to node id, wrapping;
  // words at or above the ring size are never owned
  function automatic logic key_is_owned(input logic [WORD_W-1:0] key);
    if (mirror_first_key <= mirror_node_id)
      return (mirror_first_key <= key) && (key <= mirror_node_id);
    return ((mirror_first_key <= key) && (key < RING_TOP)) || (key <= mirror_node_id);
  endfunction

  // one input item in, one result out; updates the mirrored state
  function automatic out_item_t next_node_reply(input in_item_t it);
    logic [WORD_W-1:0] w0, w1, w2, w3, w4;
    logic [WORD_W-1:0] span, new_id, key;
    logic              send;
    kind_t             kind;
    logic [RANK_W-1:0] dest;
    report_t           rep;
    out_item_t         r;
    w0 = it.word_a;
    w1 = it.word_b;
    w2 = it.word_c;
    w3 = it.word_d;
    w4 = it.word_e;
    send = 1'b0;
    kind = KIND_LOOKUP;
    dest = '0;
    rep  = REP_NONE;
    case (it.action)
      ACT_LOOKUP: begin
        // owner answers with its id and rank, everyone else passes it on
        if (key_is_owned(w1)) begin
          w2 = mirror_node_id;
          w3 = mirror_own_rank;
          kind = KIND_LOOKUP_REPLY;
        end
        send = 1'b1;
        dest = mirror_succ_rank;
      end
      ACT_LOOKUP_REPLY: begin
        if (w0 == mirror_node_id) begin
          rep = REP_LOOKUP_DONE;
        end else begin
          send = 1'b1;
          kind = KIND_LOOKUP_REPLY;
          dest = mirror_succ_rank;
        end
      end
      ACT_LEAVE: begin
        mirror_first_key = w0 & ID_MASK;
        w2 = mirror_node_id;
        w3 = mirror_own_rank;
        send = 1'b1;
        kind = KIND_LEAVE_REPLY;
        dest = mirror_succ_rank;
      end
      ACT_LEAVE_REPLY: begin
        if (w1 == mirror_succ_id) begin
          // forward to the old successor, then splice it out
          send = 1'b1;
          kind = KIND_LEAVE_REPLY;
          dest = mirror_succ_rank;
          mirror_succ_id   = w2 & ID_MASK;
          mirror_succ_rank = w3;
        end else if (w1 == mirror_node_id) begin
          rep = REP_LEAVE_DONE;
        end else begin
          send = 1'b1;
          kind = KIND_LEAVE_REPLY;
          dest = mirror_succ_rank;
        end
      end
      ACT_JOIN: begin
        send = 1'b1;
        dest = mirror_succ_rank;
        if (mirror_first_key == mirror_node_id) begin
          kind = KIND_JOIN;
        end else begin
          if (mirror_first_key < mirror_node_id)
            span = mirror_node_id - mirror_first_key;
          else
            span = RING_TOP - mirror_first_key + mirror_node_id;
          new_id = WORD_W'(int'(mirror_first_key) + int'(it.random_word) % int'(span))
                   & ID_MASK;
          w1 = new_id;
          w2 = mirror_node_id;
          w3 = mirror_own_rank;
          w4 = mirror_first_key;
          mirror_first_key = (new_id + WORD_W'(1)) & ID_MASK;
          kind = KIND_JOIN_REPLY;
        end
      end
      ACT_JOIN_REPLY: begin
        if (w0 == mirror_own_rank) begin
          mirror_node_id   = w1 & ID_MASK;
          mirror_succ_id   = w2 & ID_MASK;
          mirror_succ_rank = w3;
          mirror_first_key = w4 & ID_MASK;
        end else begin
          if (w2 == mirror_succ_id) begin
            mirror_succ_id   = w1 & ID_MASK;
            mirror_succ_rank = w0;
          end
          send = 1'b1;
          kind = KIND_JOIN_REPLY;
          dest = mirror_succ_rank;
        end
      end
      ACT_IGNORE: begin
        if (w0 == mirror_node_id) begin
          if (!key_is_owned(w1))
            rep = REP_NOT_FOUND;
        end else begin
          send = 1'b1;
          kind = KIND_IGNORE;
          dest = mirror_succ_rank;
        end
      end
      ACT_START_LOOKUP: begin
        key = w1;
        {w0, w1, w2, w3, w4} = '0;
        w0 = mirror_node_id;
        w1 = key;
        kind = key_is_owned(key) ? KIND_IGNORE : KIND_LOOKUP;
        send = 1'b1;
        dest = mirror_succ_rank;
      end
      ACT_START_LEAVE: begin
        {w0, w1, w2, w3, w4} = '0;
        w0 = mirror_first_key;
        w1 = mirror_node_id;
        send = 1'b1;
        kind = KIND_LEAVE;
        dest = mirror_succ_rank;
      end
      ACT_START_JOIN: begin
        {w0, w1, w2, w3, w4} = '0;
        w0 = mirror_own_rank;
        send = 1'b1;
        kind = KIND_JOIN;
        dest = it.target_peer;
      end
      ACT_LOAD_STATE: begin
        mirror_node_id   = w0 & ID_MASK;
        mirror_first_key = w1 & ID_MASK;
        mirror_succ_id   = w2 & ID_MASK;
        mirror_succ_rank = w3;
      end
      default: ;
    endcase
    // words are echoed with a report, cleared when nothing goes out and nothing is reported
    if (!send && rep == REP_NONE)
      {w0, w1, w2, w3, w4} = '0;
    r = '0;
    r.send_valid = send;
    if (send) begin
      r.send_kind = kind;
      r.send_dest = dest;
    end
    r.out_a  = w0;
    r.out_b  = w1;
    r.out_c  = w2;
    r.out_d  = w3;
    r.out_e  = w4;
    r.report = rep;
    return r;
  endfunction

  function automatic in_item_t mk_in(input logic [3:0] act,
                                     input logic [WORD_W-1:0] a, b, c, d, e,
                                     input logic [RAND_W-1:0] rnd,
                                     input logic [RANK_W-1:0] peer);
    in_item_t it;
    it.action      = act;
    it.word_a      = a;
    it.word_b      = b;
    it.word_c      = c;
    it.word_d      = d;
    it.word_e      = e;
    it.random_word = rnd;
    it.target_peer = peer;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic sv, input kind_t k,
                                       input logic [RANK_W-1:0] dest,
                                       input logic [WORD_W-1:0] a, b, c, d, e,
                                       input report_t rep);
    out_item_t r;
    r.send_valid = sv;
    r.send_kind  = k;
    r.send_dest  = dest;
    r.out_a      = a;
    r.out_b      = b;
    r.out_c      = c;
    r.out_d      = d;
    r.out_e      = e;
    r.report     = rep;
    return r;
  endfunction

  task automatic add_row(input in_item_t it, input logic known, input out_item_t typed);
    dir_in.push_back(it);
    dir_known.push_back(known);
    dir_exp.push_back(typed);
  endtask

  // words lean toward the values that make the node match or own something
  function automatic logic [WORD_W-1:0] biased_word(input logic [WORD_W-1:0] likely, other);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      return likely;
    if (pick < 5)
      return other;
    if (pick < 8)
      return WORD_W'($urandom_range(0, int'(ID_MASK)));
    return WORD_W'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6)
      it.action = ACT_LOAD_STATE;
    else if (pick < 10)
      it.action = 4'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
    else
      it.action = 4'($urandom_range(ACT_LOOKUP, ACT_START_JOIN));
    it.word_a      = biased_word(mirror_node_id, mirror_own_rank);
    it.word_b      = biased_word(mirror_node_id, mirror_succ_id);
    it.word_c      = biased_word(mirror_succ_id, mirror_node_id);
    it.word_d      = biased_word(mirror_succ_rank, mirror_own_rank);
    it.word_e      = biased_word(mirror_first_key, mirror_node_id);
    it.random_word = RAND_W'($urandom);
    it.target_peer = RANK_W'($urandom);
    return it;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)
      return int'($urandom_range(1, 3));
    if (pick < 95)
      return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 40));
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    $display("%0t result %0d mismatch: %s", $time, replies_seen, what);
  endtask

  task automatic check_reply(input out_item_t got, input out_item_t exp);
    if (got.send_valid !== exp.send_valid)
      log_mismatch($sformatf("send_valid exp %0d got %0d", exp.send_valid, got.send_valid));
    if (got.send_kind !== exp.send_kind)
      log_mismatch($sformatf("send_kind exp %0d got %0d", exp.send_kind, got.send_kind));
    if (got.send_dest !== exp.send_dest)
      log_mismatch($sformatf("send_dest exp %0d got %0d", exp.send_dest, got.send_dest));
    if (got.out_a !== exp.out_a)
      log_mismatch($sformatf("out_a exp %0d got %0d", exp.out_a, got.out_a));
    if (got.out_b !== exp.out_b)
      log_mismatch($sformatf("out_b exp %0d got %0d", exp.out_b, got.out_b));
    if (got.out_c !== exp.out_c)
      log_mismatch($sformatf("out_c exp %0d got %0d", exp.out_c, got.out_c));
    if (got.out_d !== exp.out_d)
      log_mismatch($sformatf("out_d exp %0d got %0d", exp.out_d, got.out_d));
    if (got.out_e !== exp.out_e)
      log_mismatch($sformatf("out_e exp %0d got %0d", exp.out_e, got.out_e));
    if (got.report !== exp.report)
      log_mismatch($sformatf("report exp %0d got %0d", exp.report, got.report));
  endtask

  // present one item, hold it until the transfer, then maybe go quiet;
  // the predictor runs at the transfer edge so state follows input order
  task automatic transfer_item(input in_item_t it, input logic known, input out_item_t typed);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted = next_node_reply(it);
    replies_due.push_back(known ? typed : predicted);
    if (sender_gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic wait_until_idle();
    while (replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver back-pressure: bursts of stall of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result side: every transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        log_mismatch($sformatf("result %h with nothing pending", out_data));
      end else begin
        check_reply(out_data, replies_due.pop_front());
      end
      replies_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [RANK_W-1:0] rank_plan [PHASES];
    mirror_node_id   = '0;
    mirror_first_key = '0;
    mirror_succ_id   = '0;
    mirror_succ_rank = '0;
    mirror_own_rank  = OWN_RANK_RST;

    // fresh state: node 0 owns only key 0, successor is rank 0, own rank 1
    add_row(mk_in(ACT_START_JOIN, 127, 127, 127, 127, 127, 16'hFFFF, 127), 1'b1,
            mk_out(1'b1, KIND_JOIN, 127, 1, 0, 0, 0, 0, REP_NONE));
    add_row(mk_in(ACT_START_LEAVE, 0, 0, 0, 0, 0, 16'h0000, 0), 1'b1,
            mk_out(1'b1, KIND_LEAVE, 0, 0, 0, 0, 0, 0, REP_NONE));
    // undecoded actions give an all-zero result
    add_row(mk_in(ACT_FIRST_UNUSED, 127, 127, 127, 127, 127, 16'hFFFF, 127), 1'b1,
            NO_REPLY);
    add_row(mk_in(ACT_LAST_UNUSED, 85, 42, 85, 42, 85, 16'hA5A5, 85), 1'b1, NO_REPLY);
    // reply addressed to us: report with words echoed
    add_row(mk_in(ACT_LOOKUP_REPLY, 0, 127, 127, 127, 127, 16'h0000, 0), 1'b1,
            mk_out(1'b0, KIND_LOOKUP, 0, 0, 127, 127, 127, 127, REP_LOOKUP_DONE));
    // join at a node owning only itself is passed on untouched
    add_row(mk_in(ACT_JOIN, 5, 6, 7, 8, 9, 16'h1234, 0), 1'b1,
            mk_out(1'b1, KIND_JOIN, 0, 5, 6, 7, 8, 9, REP_NONE));
    // own key found: nothing goes out, words cleared
    add_row(mk_in(ACT_IGNORE, 0, 0, 1, 2, 3, 16'h0000, 0), 1'b1, NO_REPLY);
    // word beyond the ring is never owned
    add_row(mk_in(ACT_IGNORE, 0, 64, 1, 2, 3, 16'h0000, 0), 1'b1,
            mk_out(1'b0, KIND_LOOKUP, 0, 0, 64, 1, 2, 3, REP_NOT_FOUND));

    // load a wrapped ownership window, ids loaded through wide words
    add_row(mk_in(ACT_LOAD_STATE, 20, 100, 127, 127, 0, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LOOKUP, 3, 10, 0, 0, 0, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LOOKUP, 3, 64, 0, 0, 0, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LOOKUP, 3, 30, 11, 12, 13, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_IGNORE, 20, 25, 4, 5, 6, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_IGNORE, 84, 0, 4, 5, 6, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_START_LOOKUP, 99, 0, 99, 99, 99, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_START_LOOKUP, 99, 127, 99, 99, 99, 16'h0000, 0), 1'b0, NO_REPLY);
    // join with the largest and the smallest draw
    add_row(mk_in(ACT_JOIN, 7, 0, 0, 0, 0, 16'hFFFF, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_JOIN, 7, 0, 0, 0, 0, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LEAVE, 127, 1, 2, 3, 4, 16'h0000, 0), 1'b0, NO_REPLY);
    // leave reply naming our successor, naming us, naming nobody
    add_row(mk_in(ACT_LEAVE_REPLY, 1, 63, 5, 0, 2, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LEAVE_REPLY, 1, 20, 5, 0, 2, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LEAVE_REPLY, 1, 127, 5, 0, 2, 16'h0000, 0), 1'b0, NO_REPLY);
    // join reply for us, then one that moves our successor
    add_row(mk_in(ACT_JOIN_REPLY, 1, 127, 70, 0, 64, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_JOIN_REPLY, 5, 9, 6, 3, 2, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_LOOKUP_REPLY, 127, 1, 2, 3, 4, 16'h0000, 0), 1'b0, NO_REPLY);
    add_row(mk_in(ACT_START_JOIN, 0, 0, 0, 0, 0, 16'h0000, 0), 1'b0, NO_REPLY);

    rank_plan[0] = '0;
    rank_plan[1] = '1;
    rank_plan[2] = RANK_W'($urandom);
    rank_plan[3] = RANK_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    sender_gaps     <= 1'b1;
    receiver_stalls <= 1'b1;
    @(posedge clk);

    foreach (dir_in[i])
      transfer_item(dir_in[i], dir_known[i], dir_exp[i]);
    in_valid <= 1'b0;

    // each phase runs under a new own rank, written while the node is idle
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_until_idle();
      cfg_we    <= 1'b1;
      cfg_wdata <= rank_plan[ph];
      @(posedge clk);
      cfg_we <= 1'b0;
      mirror_own_rank = rank_plan[ph];
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // idle pattern changes in stretches, including fully busy ones
        if (n % 100 == 0) begin
          sender_gaps     <= 1'($urandom_range(0, 1));
          receiver_stalls <= 1'($urandom_range(0, 1));
        end
        transfer_item(random_item(), 1'b0, NO_REPLY);
      end
      in_valid <= 1'b0;
    end

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rkln_pkg.sv
design/rkln_front.sv
design/rkln_fifo.sv
design/rkln_back.sv
design/ring_key_lookup_node_top.sv
tb/ring_key_lookup_node_top_tb.sv
